// File: rtl/core/plid_pkg.sv
// Shared constants, codes and controller/datapath interface types for the positional list.
`default_nettype none

package plid_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 7;
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      FUNC_INS_FRONT = 2'd0,
      FUNC_INS_BACK  = 2'd1,
      FUNC_INS_POS   = 2'd2,
      FUNC_DEL       = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EVAL,
      S_INS_MOVE,
      S_INS_PUT,
      S_DEL_READ,
      S_DEL_MOVE,
      S_DRAIN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic move;
      logic fetch;
      logic put;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic ok;
      logic is_del;
      logic no_move;
      logic last;
      logic rsp_free;
   } ctrl_sts_type;

endpackage

`default_nettype wire

// File: rtl/core/plid_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module plid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/plid_ctrl.sv
// Controller state machine sequencing insert and delete transactions.
`default_nettype none

module plid_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire plid_pkg::ctrl_sts_type sts,
   output plid_pkg::ctrl_cmd_type     cmd
);

   plid_pkg::state_type state_ff;
   plid_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plid_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plid_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = plid_pkg::S_EVAL;
            end
         end
         plid_pkg::S_EVAL: begin
            priority if (!sts.ok) begin
               state_in = plid_pkg::S_DONE;
            end else if (sts.is_del) begin
               state_in = plid_pkg::S_DEL_READ;
            end else if (sts.no_move) begin
               state_in = plid_pkg::S_INS_PUT;
            end else begin
               state_in = plid_pkg::S_INS_MOVE;
            end
         end
         plid_pkg::S_INS_MOVE: begin
            if (sts.last) begin
               state_in = plid_pkg::S_DRAIN;
            end
         end
         plid_pkg::S_INS_PUT: begin
            state_in = plid_pkg::S_DONE;
         end
         plid_pkg::S_DEL_READ: begin
            if (sts.no_move) begin
               state_in = plid_pkg::S_DRAIN;
            end else begin
               state_in = plid_pkg::S_DEL_MOVE;
            end
         end
         plid_pkg::S_DEL_MOVE: begin
            if (sts.last) begin
               state_in = plid_pkg::S_DRAIN;
            end
         end
         plid_pkg::S_DRAIN: begin
            if (sts.is_del) begin
               state_in = plid_pkg::S_DONE;
            end else begin
               state_in = plid_pkg::S_INS_PUT;
            end
         end
         plid_pkg::S_DONE: begin
            if (sts.rsp_free) begin
               state_in = plid_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = plid_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         plid_pkg::S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         plid_pkg::S_EVAL: begin
            cmd.eval = 1'b1;
         end
         plid_pkg::S_INS_MOVE, plid_pkg::S_DEL_MOVE: begin
            cmd.move = 1'b1;
         end
         plid_pkg::S_INS_PUT: begin
            cmd.put = 1'b1;
         end
         plid_pkg::S_DEL_READ: begin
            cmd.fetch = 1'b1;
         end
         plid_pkg::S_DONE: begin
            cmd.finish = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/plid_datapath.sv
// Datapath: list store, length, shift pointer and response register.
`default_nettype none

module plid_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire plid_pkg::ctrl_cmd_type               cmd,
   output plid_pkg::ctrl_sts_type                    sts,
   input  wire logic [1:0]                           req_func,
   input  wire logic [plid_pkg::CNT_W-1:0]           req_position,
   input  wire logic signed [plid_pkg::DATA_W-1:0]   req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_status,
   output logic signed [plid_pkg::DATA_W-1:0]        rsp_removed_value,
   output logic [plid_pkg::CNT_W-1:0]                rsp_length
);

   localparam int AW = plid_pkg::ADDR_W;
   localparam int CW = plid_pkg::CNT_W;
   localparam int DW = plid_pkg::DATA_W;

   plid_pkg::func_type   func_ff;
   logic [CW-1:0]        tgt_ff;
   logic [DW-1:0]        value_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic [AW-1:0]        ptr_ff;
   logic                 wb_pending_ff;
   logic [AW-1:0]        wb_addr_ff;
   logic                 fetch_pending_ff;
   logic [DW-1:0]        removed_ff;
   logic                 rsp_valid_ff;
   plid_pkg::status_type rsp_status_ff;
   logic [DW-1:0]        rsp_removed_ff;
   logic [CW-1:0]        rsp_length_ff;

   plid_pkg::func_type   req_func_t;
   plid_pkg::status_type status_code;
   logic [CW-1:0]        tgt_in;
   logic                 is_del;
   logic                 bad;
   logic                 full;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [DW-1:0]        ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [DW-1:0]        ram_rd_data;

   assign req_func_t = plid_pkg::func_type'(req_func);

   always_comb begin
      unique case (req_func_t)
         plid_pkg::FUNC_INS_FRONT: tgt_in = '0;
         plid_pkg::FUNC_INS_BACK:  tgt_in = count_ff;
         plid_pkg::FUNC_INS_POS:   tgt_in = req_position;
         plid_pkg::FUNC_DEL:       tgt_in = req_position;
         default:                  tgt_in = req_position;
      endcase
   end

   assign is_del = (func_ff == plid_pkg::FUNC_DEL);
   assign bad    = ((func_ff == plid_pkg::FUNC_INS_POS) && (tgt_ff > count_ff)) ||
                   (is_del && (tgt_ff >= count_ff));
   assign full   = !is_del && (count_ff == CW'(plid_pkg::CAPACITY));

   always_comb begin
      priority if (bad) begin
         status_code = plid_pkg::ST_BAD_INDEX;
      end else if (full) begin
         status_code = plid_pkg::ST_FULL;
      end else begin
         status_code = plid_pkg::ST_OK;
      end
   end

   always_comb begin
      sts.ok       = (status_code == plid_pkg::ST_OK);
      sts.is_del   = is_del;
      sts.no_move  = is_del ? (CW'(tgt_ff + CW'(1)) == count_ff) : (tgt_ff == count_ff);
      sts.last     = is_del ? (ptr_ff == AW'(count_ff - CW'(1))) : (ptr_ff == tgt_ff[AW-1:0]);
      sts.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      count_in = count_ff;
      if (sts.ok) begin
         count_in = is_del ? CW'(count_ff - CW'(1)) : CW'(count_ff + CW'(1));
      end
   end

   assign ram_wr_en   = wb_pending_ff || cmd.put;
   assign ram_wr_addr = wb_pending_ff ? wb_addr_ff : tgt_ff[AW-1:0];
   assign ram_wr_data = wb_pending_ff ? ram_rd_data : value_ff;
   assign ram_rd_en   = cmd.move || cmd.fetch;
   assign ram_rd_addr = cmd.fetch ? tgt_ff[AW-1:0] : ptr_ff;

   plid_ram #(
      .WIDTH (DW),
      .DEPTH (plid_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func_t;
         tgt_ff   <= tgt_in;
         value_ff <= req_value;
      end
      if (cmd.eval) begin
         ptr_ff <= is_del ? AW'(tgt_ff + CW'(1)) : AW'(count_ff - CW'(1));
      end else if (cmd.move) begin
         ptr_ff <= is_del ? AW'(ptr_ff + AW'(1)) : AW'(ptr_ff - AW'(1));
      end
      if (cmd.move) begin
         wb_addr_ff <= is_del ? AW'(ptr_ff - AW'(1)) : AW'(ptr_ff + AW'(1));
      end
      if (fetch_pending_ff) begin
         removed_ff <= ram_rd_data;
      end
      if (cmd.finish) begin
         rsp_status_ff  <= status_code;
         rsp_removed_ff <= (sts.ok && is_del) ? removed_ff : '0;
         rsp_length_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         wb_pending_ff    <= 1'b0;
         fetch_pending_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         wb_pending_ff    <= cmd.move;
         fetch_pending_ff <= cmd.fetch;
         if (cmd.finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_length        = rsp_length_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(plid_pkg::CAPACITY))
      else $error("list length above capacity");

   a_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(wb_pending_ff && cmd.put))
      else $error("shift write and value write in the same cycle");

   a_length_track: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_length_ff == count_ff) && rsp_valid_ff)
      else $error("reported length differs from stored length");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != plid_pkg::ST_OK)) |-> (rsp_removed_ff == '0))
      else $error("removed value not zero on a failed transaction");
`endif

endmodule

`default_nettype wire

// File: rtl/core/positional_list_insert_delete.sv
// Top level of the positional list: controller and datapath.
// Holds an ordered list of up to 64 signed 32-bit values in a single-port-write RAM.
// Request channel (req_): func, position and value; a transaction is taken when
//   req_valid is high and req_stall low. req_stall is low only while the block is idle.
// Response channel (rsp_): status, removed_value and length; a transaction completes
//   when rsp_valid is high and rsp_stall low. Exactly one response per request.
// Sequence: an insert that moves entries passes through EVAL, INS_MOVE, DRAIN, INS_PUT
//   and DONE, and one that moves nothing through EVAL, INS_PUT and DONE; a delete
//   through EVAL, DEL_READ, DEL_MOVE (when entries move), DRAIN and DONE; a rejected
//   request, EVAL and DONE. Entries are moved one per cycle through the RAM's
//   registered read port.
// Throughput: one transaction at a time; the next request is taken once the
//   previous one has been written to the response register.
// A stalled response holds in its register; the block may take and work on the next
//   request meanwhile but does not complete it until the response register is free.
// Reset empties the list at once; no clearing pass runs over the store.
`default_nettype none

module positional_list_insert_delete (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_func,
   input  wire logic [plid_pkg::CNT_W-1:0]           req_position,
   input  wire logic signed [plid_pkg::DATA_W-1:0]   req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_status,
   output logic signed [plid_pkg::DATA_W-1:0]        rsp_removed_value,
   output logic [plid_pkg::CNT_W-1:0]                rsp_length
);

   plid_pkg::ctrl_cmd_type cmd;
   plid_pkg::ctrl_sts_type sts;

   plid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   plid_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_length        (rsp_length)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for the positional list: queued stimulus, list predictor and response checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import plid_pkg::*;

   typedef struct {
      func_type                   func;
      logic [CNT_W-1:0]           position;
      logic signed [DATA_W-1:0]   value;
   } list_cmd_t;

   typedef struct {
      status_type                 status;
      logic signed [DATA_W-1:0]   removed_value;
      logic [CNT_W-1:0]           length;
   } list_rsp_t;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [1:0]                  req_func = FUNC_INS_FRONT;
   logic [CNT_W-1:0]            req_position = '0;
   logic signed [DATA_W-1:0]    req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [1:0]                  rsp_status;
   logic signed [DATA_W-1:0]    rsp_removed_value;
   logic [CNT_W-1:0]            rsp_length;

   list_cmd_t                   queued_list_cmds[$];
   list_rsp_t                   pending_list_rsps[$];
   logic signed [DATA_W-1:0]    list_model[$];
   int                          gen_len = 0;
   int                          req_idle_pct = 0;
   int                          rsp_stall_pct = 0;
   int                          error_count = 0;

   positional_list_insert_delete u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_length        (rsp_length)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic list_rsp_t apply_list_cmd(func_type f, logic [CNT_W-1:0] pos,
                                                logic signed [DATA_W-1:0] v);
      list_rsp_t r;
      r.status        = ST_OK;
      r.removed_value = '0;
      case (f)
         FUNC_INS_FRONT: begin
            if (list_model.size() >= CAPACITY) r.status = ST_FULL;
            else list_model.push_front(v);
         end
         FUNC_INS_BACK: begin
            if (list_model.size() >= CAPACITY) r.status = ST_FULL;
            else list_model.push_back(v);
         end
         FUNC_INS_POS: begin
            if (pos > list_model.size()) r.status = ST_BAD_INDEX;
            else if (list_model.size() >= CAPACITY) r.status = ST_FULL;
            else list_model.insert(pos, v);
         end
         default: begin
            if (pos >= list_model.size()) begin
               r.status = ST_BAD_INDEX;
            end else begin
               r.removed_value = list_model[pos];
               list_model.delete(pos);
            end
         end
      endcase
      r.length = CNT_W'(list_model.size());
      return r;
   endfunction

   // queue a command and advance the running length used to shape positions
   task automatic push_cmd(func_type f, int pos, logic [DATA_W-1:0] v);
      list_cmd_t c;
      c.func     = f;
      c.position = CNT_W'(pos);
      c.value    = v;
      queued_list_cmds.push_back(c);
      case (f)
         FUNC_INS_FRONT, FUNC_INS_BACK: if (gen_len < CAPACITY) gen_len++;
         FUNC_INS_POS: if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
         default: if (pos < gen_len) gen_len--;
      endcase
   endtask

   task automatic push_random_cmds(int count);
      func_type           f;
      int                 pos;
      int                 ins_pct;
      logic [DATA_W-1:0]  v;
      ins_pct = 55;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: ins_pct = 85;
               1: ins_pct = 20;
               default: ins_pct = 55;
            endcase
         end
         case ($urandom_range(0, 19))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            default: v = $urandom;
         endcase
         if ($urandom_range(0, 99) < ins_pct) f = func_type'($urandom_range(0, 2));
         else f = FUNC_DEL;
         case (f)
            FUNC_INS_POS: begin
               if ($urandom_range(0, 9) == 0) pos = $urandom_range(gen_len + 1, 127);
               else pos = $urandom_range(0, gen_len);
            end
            FUNC_DEL: begin
               if (gen_len == 0 || $urandom_range(0, 9) == 0) pos = $urandom_range(gen_len, 127);
               else pos = $urandom_range(0, gen_len - 1);
            end
            default: pos = $urandom_range(0, 127);
         endcase
         push_cmd(f, pos, v);
      end
   endtask

   // driver: hold the payload until taken, then present the next queued command
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_list_rsps.push_back(apply_list_cmd(func_type'(req_func), req_position,
                                                       req_value));
         end
         if (!req_valid || !req_stall) begin
            if (queued_list_cmds.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               req_valid    <= 1'b1;
               req_func     <= queued_list_cmds[0].func;
               req_position <= queued_list_cmds[0].position;
               req_value    <= queued_list_cmds[0].value;
               void'(queued_list_cmds.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each response transaction against the oldest prediction
   always @(posedge clock) begin
      list_rsp_t exp_rsp;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_list_rsps.size() == 0) begin
               $error("unexpected response: status %0d removed_value %0d length %0d",
                      rsp_status, rsp_removed_value, rsp_length);
               error_count++;
            end else begin
               exp_rsp = pending_list_rsps.pop_front();
               if (rsp_status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d", exp_rsp.status, rsp_status);
                  error_count++;
               end
               if (rsp_removed_value !== exp_rsp.removed_value) begin
                  $error("removed_value: expected %0d, got %0d", exp_rsp.removed_value,
                         rsp_removed_value);
                  error_count++;
               end
               if (rsp_length !== exp_rsp.length) begin
                  $error("length: expected %0d, got %0d", exp_rsp.length, rsp_length);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 73; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 73; end
            default: begin req_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         if (phase == 0) begin
            push_cmd(FUNC_DEL, 0, 32'h0);
            push_cmd(FUNC_INS_POS, 1, 32'h1);
            push_cmd(FUNC_INS_POS, 0, 32'h7FFF_FFFF);
            push_cmd(FUNC_INS_FRONT, 127, 32'h8000_0000);
            push_cmd(FUNC_INS_BACK, 127, 32'h0);
            push_cmd(FUNC_INS_BACK, 0, 32'hFFFF_FFFF);
            push_cmd(FUNC_INS_POS, 2, 32'h1234_5678);
            push_cmd(FUNC_INS_POS, 5, 32'h0000_0055);
            push_cmd(FUNC_INS_POS, 7, 32'h0000_00AA);
            push_cmd(FUNC_DEL, 127, 32'hFFFF_FFFF);
            push_cmd(FUNC_DEL, 6, 32'h0);
            push_cmd(FUNC_DEL, 5, 32'h0);
            push_cmd(FUNC_DEL, 0, 32'h0);
            push_cmd(FUNC_DEL, 2, 32'h0);
            for (int k = 0; k < 3; k++) push_cmd(FUNC_DEL, 0, 32'h0);
            push_cmd(FUNC_DEL, 0, 32'h0);
            // fill to capacity, then probe the full list
            while (gen_len < CAPACITY) push_cmd(FUNC_INS_BACK, 0, $urandom);
            push_cmd(FUNC_INS_FRONT, 0, 32'h1);
            push_cmd(FUNC_INS_BACK, 0, 32'h2);
            push_cmd(FUNC_INS_POS, 64, 32'h3);
            push_cmd(FUNC_INS_POS, 65, 32'h4);
            push_cmd(FUNC_INS_POS, 0, 32'h5);
            push_cmd(FUNC_DEL, 63, 32'h0);
            push_cmd(FUNC_INS_POS, 63, 32'h8000_0000);
            push_cmd(FUNC_DEL, 64, 32'h0);
            push_cmd(FUNC_DEL, 0, 32'h0);
            push_random_cmds(400);
         end else begin
            push_random_cmds(phase == 3 ? 390 : 330);
         end
         // hold off the sender until every response of the phase has arrived
         while (queued_list_cmds.size() != 0 || req_valid || pending_list_rsps.size() != 0)
            @(posedge clock);
      end

      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
